@@ rtl/core/tfir_pkg.sv @@
// Package for the transposed-form Q15 FIR core.
// Holds the operation codes, sequencer state type and fixed-point constants.
// No dependencies.
package tfir_pkg;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [31:0] ROUND_CONST = 32'h0000_4000;
  localparam int          FRAC_BITS   = 15;
  localparam int          SAMPLE_W    = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } tfir_state_t;

endpackage

@@ rtl/core/transposed_fir_filter_core.sv @@
// Transposed-form FIR filter core, Q15 samples and coefficients.
// Depends on tfir_pkg (operation codes, state type, rounding constants).
//
// A coefficient load is taken while idle and gives no result. A sample runs
// one multiply-accumulate per tap through a single shared 16x16 multiplier and
// a single partial-sum write port, so it occupies the core from acceptance until
// the next item can be taken; in_ready is low meanwhile. The filtered sample
// then waits in an output register and does not hold up the next item, unless
// a second result is due before the first is taken.
// Partial sums and coefficients live in memories whose entries read as zero
// until written after reset (per-entry valid bits), so no clearing pass runs.
// Tap indexes at or beyond TAPS are ignored on load.
module transposed_fir_filter_core
  import tfir_pkg::*;
#(
  parameter int TAPS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [5:0]         in_tap_index,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_filtered_sample
);

  localparam int IDX_W = $clog2(TAPS);

  tfir_state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             issue;
  logic             load_out;
  logic             cnt_last;
  logic [IDX_W-1:0] ps_addr;
  logic             in_acc;
  logic             coef_we;

  logic signed [15:0] sample_r;

  logic signed [15:0] coef_mem [TAPS];
  logic [31:0]        ps_mem [TAPS];
  logic [TAPS-1:0]    coef_vld_r;
  logic [TAPS-1:0]    ps_vld_r;

  // stage 1: registered memory reads
  logic               s1_vld_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               s1_last_r;
  logic signed [15:0] coef_rd_r;
  logic [31:0]        ps_rd_r;
  logic               coef_ok_r;
  logic               ps_ok_r;
  logic signed [15:0] coef_op;

  // stage 2: registered product and addend
  logic               s2_vld_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic               s2_last_r;
  logic signed [31:0] prod_r;
  logic [31:0]        add_r;
  logic               s2_first;
  logic [31:0]        round_add;
  logic [31:0]        wsum;

  logic signed [15:0] res_r;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;

  assign in_acc   = in_valid && in_ready;
  assign coef_we  = in_acc && (in_operation == OP_LOAD) && (int'(in_tap_index) < TAPS);
  assign cnt_last = (cnt_r == IDX_W'(TAPS - 1));
  // the last tap has no upstream partial sum; park the address at zero
  assign ps_addr  = cnt_last ? '0 : IDX_W'(cnt_r + 1'b1);
  assign issue    = (state_r == ST_RUN) && !iss_done_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      iss_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      iss_done_r <= iss_done_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    iss_done_nxt = iss_done_r;
    load_out     = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_operation == OP_FILTER)) begin
          state_nxt    = ST_RUN;
          cnt_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end
      ST_RUN: begin
        if (!iss_done_r) begin
          if (cnt_last) begin
            iss_done_nxt = 1'b1;
          end else begin
            cnt_nxt = IDX_W'(cnt_r + 1'b1);
          end
        end
        if (s2_vld_r && s2_last_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_FILTER)) begin
      sample_r <= in_value;
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[IDX_W'(in_tap_index)] <= in_value;
    end
    coef_rd_r <= coef_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[IDX_W'(in_tap_index)] <= 1'b1;
    end
  end

  // partial-sum memory: reads run ahead of writes by more than one tap
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      ps_mem[s2_idx_r] <= wsum;
    end
    ps_rd_r <= ps_mem[ps_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_vld_r <= '0;
    end else if (s2_vld_r) begin
      ps_vld_r[s2_idx_r] <= 1'b1;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= cnt_r;
    s1_last_r <= cnt_last;
    coef_ok_r <= coef_vld_r[cnt_r];
    ps_ok_r   <= ps_vld_r[ps_addr] && !cnt_last;
  end

  assign coef_op = coef_ok_r ? coef_rd_r : '0;

  // stage 2: the shared multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    prod_r    <= sample_r * coef_op;
    add_r     <= ps_ok_r ? ps_rd_r : '0;
  end

  // stage 3: accumulate and write back; tap zero also takes the rounding
  assign s2_first  = (s2_idx_r == '0);
  assign round_add = s2_first ? ROUND_CONST : '0;
  assign wsum      = $unsigned(prod_r) + add_r + round_add;

  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_first) begin
      res_r <= wsum[FRAC_BITS +: SAMPLE_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;

  // pipeline must be empty whenever a new item can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_vld_r && !s2_vld_r))
    else $error("tap pipeline busy while idle");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_FILTER)) |=> (state_r == ST_RUN))
    else $error("accepted sample did not start the tap sweep");

  a_finish_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && ($past(state_r) == ST_RUN)) |-> $past(s2_vld_r && s2_last_r))
    else $error("sweep finished before the last tap was written");

endmodule

@@ dv/tb_transposed_fir_filter_core.sv @@
// Self-checking bench for the transposed-form Q15 FIR core: a directed table of
// items, then random loads and samples, each filtered sample checked in order.
// Depends on tfir_pkg and transposed_fir_filter_core.
module tb_transposed_fir_filter_core;
  import tfir_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS       = 64;
  localparam int N_RANDOM   = 1330;
  localparam int PERIOD     = 8;
  localparam int IDLE_PCT   = 32;
  localparam int LOAD_PCT   = 12;

  typedef struct packed {
    logic               op;
    logic [5:0]         idx;
    logic signed [15:0] value;
    logic               fixed;   // expected output typed in below
    logic signed [15:0] want;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // all coefficients zero after reset: every sample rounds to zero
    '{OP_FILTER, 6'd0,  16'sh0000, 1'b1, 16'sh0000},
    '{OP_FILTER, 6'd63, 16'sh7fff, 1'b1, 16'sh0000},
    '{OP_FILTER, 6'd42, 16'sh8000, 1'b1, 16'sh0000},
    // most negative squared lands on bit 30, output wraps to -32768
    '{OP_LOAD,   6'd0,  16'sh8000, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh8000, 1'b1, 16'sh8000},
    '{OP_LOAD,   6'd1,  16'sh8000, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh8000, 1'b0, 16'sh0000},
    // two taps of 2^30 push the sum past 2^31
    '{OP_FILTER, 6'd0,  16'sh8000, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh7fff, 1'b0, 16'sh0000},
    '{OP_LOAD,   6'd63, 16'sh7fff, 1'b0, 16'sh0000},
    '{OP_LOAD,   6'd62, 16'sh7fff, 1'b0, 16'sh0000},
    '{OP_LOAD,   6'd32, 16'sh0001, 1'b0, 16'sh0000},
    '{OP_LOAD,   6'd5,  16'sh0000, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd21, 16'sh7fff, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh0001, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'shffff, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh0000, 1'b0, 16'sh0000},
    '{OP_LOAD,   6'd0,  16'sh7fff, 1'b0, 16'sh0000},
    '{OP_LOAD,   6'd1,  16'shffff, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh8000, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh7fff, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh0000, 1'b0, 16'sh0000},
    '{OP_FILTER, 6'd0,  16'sh0000, 1'b0, 16'sh0000}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_operation;
  logic [5:0]         in_tap_index;
  logic signed [15:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_filtered_sample;

  logic signed [15:0] tap_coef [TAPS];
  logic [31:0]        tap_acc  [TAPS];
  logic signed [15:0] pending_filtered [$];
  int                 mismatches;
  bit                 gaps_on;

  transposed_fir_filter_core #(.TAPS(TAPS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_tap_index        (in_tap_index),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample)
  );

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // Advance the partial-sum row by one sample and return the rounded output.
  function automatic logic signed [15:0] filter_sample(logic signed [15:0] x);
    logic signed [31:0] prod;
    logic [31:0]        rounded;
    for (int k = 0; k < TAPS - 1; k++) begin
      prod       = x * tap_coef[k];
      tap_acc[k] = prod + tap_acc[k + 1];
    end
    prod             = x * tap_coef[TAPS - 1];
    tap_acc[TAPS - 1] = prod;
    rounded    = tap_acc[0] + ROUND_CONST;
    tap_acc[0] = rounded;
    return rounded[FRAC_BITS +: SAMPLE_W];
  endfunction

  // Present one item, hold it until taken, then update the predicted state.
  task automatic send_item(logic op, logic [5:0] idx, logic signed [15:0] value,
                           logic fixed, logic signed [15:0] want);
    logic signed [15:0] predicted;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_tap_index = idx;
    in_value     = value;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) begin
      if (idx < TAPS) tap_coef[idx] = value;
    end else begin
      predicted = filter_sample(value);
      pending_filtered.push_back(fixed ? want : predicted);
    end
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    out_ready = !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_filtered.size() == 0) begin
        $error("filtered_sample: unexpected item, actual %0d", out_filtered_sample);
        mismatches++;
      end else begin
        if (out_filtered_sample !== pending_filtered[0]) begin
          $error("filtered_sample: expected %0d, actual %0d",
                 pending_filtered[0], out_filtered_sample);
          mismatches++;
        end
        void'(pending_filtered.pop_front());
      end
    end
  end

  initial begin
    logic op;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_FILTER;
    in_tap_index = '0;
    in_value     = '0;
    out_ready    = 1'b0;
    mismatches   = 0;
    gaps_on      = 1'b1;
    for (int k = 0; k < TAPS; k++) begin
      tap_coef[k] = '0;
      tap_acc[k]  = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].value,
                DIRECTED[i].fixed, DIRECTED[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      // hold both sides busy for a stretch in the middle
      gaps_on = !(i >= 400 && i < 600);
      op = ($urandom_range(0, 99) < LOAD_PCT) ? OP_LOAD : OP_FILTER;
      send_item(op, 6'($urandom_range(0, 63)), pick_value(), 1'b0, 16'sh0000);
    end

    @(negedge clk);
    in_valid = 1'b0;
    gaps_on  = 1'b1;
    wait (pending_filtered.size() == 0);
    repeat (TAPS + 16) @(posedge clk);
    if (mismatches == 0 && pending_filtered.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Drop out if the handshakes stall.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
